// ----- sv/fatdl_pkg.sv -----
package fatdl_pkg;

   // directory size the search is built for
   localparam int DIR_ENTRIES_DEFAULT = 1024;

   localparam int NAME_BYTES = 11;
   localparam int BASE_BYTES = 8;
   localparam int FILL_W     = 4;
   localparam int LIMIT_W    = 11;
   localparam int INDEX_W    = 10;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd224;
   localparam logic [7:0]         CHAR_SPACE  = 8'h20;
   localparam logic [7:0]         CHAR_DOT    = 8'h2E;
   localparam logic [7:0]         CHAR_LOW_A  = 8'h61;
   localparam logic [7:0]         CHAR_LOW_Z  = 8'h7A;
   localparam logic [7:0]         CASE_OFFSET = 8'h20;
   // volume label and subdirectory bits
   localparam logic [7:0]         ATTR_SKIP   = 8'h18;

   typedef enum logic [1:0] {
      PHASE_COLLECT = 2'd0,
      PHASE_ENDED   = 2'd1,
      PHASE_SEARCH  = 2'd2,
      PHASE_IDLE    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_FOUND = 2'd0,
      ST_END   = 2'd1,
      ST_LONG  = 2'd2,
      ST_LIMIT = 2'd3
   } status_type;

   typedef enum logic {
      CMD_NAME  = 1'b0,
      CMD_ENTRY = 1'b1
   } command_type;

endpackage

// ----- sv/fat_short_name_dir_lookup_unit.sv -----
// 8.3 short-name directory lookup. Send the file name first, one character per
// transfer with command 0 (a zero character ends the name, name_last on the final
// character opens the search), then the directory entries in order with command 1.
// The unit answers with at most one response per search: the index of the first
// entry whose 11 name bytes match (volume labels and subdirectories are skipped),
// end-marker when an entry starting with a zero byte arrives, limit-reached after
// entry_limit entries (capped at DIR_ENTRIES), or name-too-long as soon as a
// character arrives with all 11 name bytes filled. A name character sent during
// or after a search starts a new name; entries sent while no search is open are
// dropped silently. One item can be accepted per clock unless the response
// register is full and not being taken, the only stall. Each item is held in
// the input register and its result, if it has one, goes to the response
// register. entry_limit may be written only while the unit is idle.
module fat_short_name_dir_lookup_unit #(
   parameter int DIR_ENTRIES = fatdl_pkg::DIR_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_we,
   input  logic [fatdl_pkg::LIMIT_W-1:0] csr_wdata,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic [7:0]                   req_name_char,
   input  logic                         req_name_last,
   input  logic [63:0]                  req_entry_base,
   input  logic [23:0]                  req_entry_ext,
   input  logic [7:0]                   req_entry_attr,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [fatdl_pkg::INDEX_W-1:0] rsp_entry_index
);
   import fatdl_pkg::*;

   // entry counter holds 0..DIR_ENTRIES; compares run at the wider of it and the limit
   localparam int CNT_W = $clog2(DIR_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   // configuration register
   logic [LIMIT_W-1:0] limit_ff;

   // input register
   logic        s1_valid_ff;
   logic        s1_command_ff;
   logic [7:0]  s1_char_ff;
   logic        s1_last_ff;
   logic [63:0] s1_base_ff;
   logic [23:0] s1_ext_ff;
   logic [7:0]  s1_attr_ff;

   // search state
   phase_type         phase_ff, phase_in;
   logic [7:0]        name_ff [NAME_BYTES];
   logic [7:0]        name_in [NAME_BYTES];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  seen_ff, seen_in;

   // response register
   logic               rsp_valid_ff;
   status_type         rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic               emit;

   logic advance;

   // shared decode of the item in the input register
   logic              is_name_item;
   logic              restart;
   phase_type         eff_phase;
   logic [FILL_W-1:0] eff_fill;
   logic              eff_ovf;
   logic              c_zero;
   logic              c_jump;
   logic              name_full;
   logic [CMP_W-1:0]  lim;
   logic [CMP_W-1:0]  seen_ext;
   logic [CMP_W-1:0]  seen_next;
   logic              at_limit;
   logic              next_at_limit;
   logic [87:0]       entry_vec;
   logic [87:0]       name_vec;
   logic              ent_end;
   logic              ent_match;
   logic [7:0]        upper_char;

   // process the held item when the response register can take a result
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   assign is_name_item = (s1_command_ff == CMD_NAME);
   // a name character during or after a search drops it and starts over
   assign restart   = is_name_item &&
                      ((phase_ff == PHASE_SEARCH) || (phase_ff == PHASE_IDLE));
   assign eff_phase = restart ? PHASE_COLLECT : phase_ff;
   assign eff_fill  = restart ? '0 : fill_ff;
   assign eff_ovf   = restart ? 1'b0 : ovf_ff;

   assign c_zero    = (s1_char_ff == 8'h00);
   assign c_jump    = (s1_char_ff == CHAR_DOT) && (eff_fill <= FILL_W'(BASE_BYTES));
   assign name_full = (eff_fill >= FILL_W'(NAME_BYTES));
   assign upper_char = ((s1_char_ff >= CHAR_LOW_A) && (s1_char_ff <= CHAR_LOW_Z)) ?
                       (s1_char_ff - CASE_OFFSET) : s1_char_ff;

   // effective limit is the register capped at the directory size
   assign lim = (CMP_W'(limit_ff) > CMP_W'(DIR_ENTRIES)) ? CMP_W'(DIR_ENTRIES)
                                                        : CMP_W'(limit_ff);
   assign seen_ext      = CMP_W'(seen_ff);
   assign seen_next     = seen_ext + CMP_W'(1);
   assign at_limit      = (seen_ext >= lim);
   assign next_at_limit = (seen_next >= lim);

   assign entry_vec = {s1_ext_ff, s1_base_ff};
   always_comb begin
      for (int k = 0; k < NAME_BYTES; k++) begin
         name_vec[8*k +: 8] = name_ff[k];
      end
   end
   assign ent_end   = (s1_base_ff[7:0] == 8'h00);
   assign ent_match = ((s1_attr_ff & ATTR_SKIP) == 8'h00) && (entry_vec == name_vec);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_name_item) begin
         phase_in = eff_phase;
         if (eff_phase == PHASE_COLLECT) begin
            if (c_zero) begin
               phase_in = PHASE_ENDED;
            end else if (!c_jump && name_full) begin
               phase_in = PHASE_ENDED;
            end
         end
         if (s1_last_ff) begin
            // an overflowed name never opens a search
            if (eff_ovf || (eff_phase == PHASE_COLLECT && !c_zero && !c_jump && name_full)) begin
               phase_in = PHASE_IDLE;
            end else begin
               phase_in = PHASE_SEARCH;
            end
         end
      end else if (phase_ff == PHASE_SEARCH) begin
         if (at_limit || ent_end || ent_match || next_at_limit) begin
            phase_in = PHASE_IDLE;
         end
      end
   end

   // name packing, entry count and result
   always_comb begin
      for (int k = 0; k < NAME_BYTES; k++) begin
         name_in[k] = restart ? CHAR_SPACE : name_ff[k];
      end
      fill_in       = eff_fill;
      ovf_in        = eff_ovf;
      seen_in       = restart ? '0 : seen_ff;
      emit          = 1'b0;
      rsp_status_in = ST_FOUND;
      rsp_index_in  = '0;
      if (is_name_item) begin
         if (eff_phase == PHASE_COLLECT && !c_zero) begin
            if (c_jump) begin
               fill_in = FILL_W'(BASE_BYTES);
            end else if (name_full) begin
               ovf_in        = 1'b1;
               emit          = 1'b1;
               rsp_status_in = ST_LONG;
            end else begin
               name_in[eff_fill] = upper_char;
               fill_in           = eff_fill + FILL_W'(1);
            end
         end
         if (s1_last_ff) begin
            seen_in = '0;
         end
      end else if (phase_ff == PHASE_SEARCH) begin
         if (at_limit) begin
            emit          = 1'b1;
            rsp_status_in = ST_LIMIT;
         end else if (ent_end) begin
            emit          = 1'b1;
            rsp_status_in = ST_END;
         end else if (ent_match) begin
            emit          = 1'b1;
            rsp_status_in = ST_FOUND;
            rsp_index_in  = seen_ext[INDEX_W-1:0];
         end else begin
            seen_in = seen_next[CNT_W-1:0];
            if (next_at_limit) begin
               emit          = 1'b1;
               rsp_status_in = ST_LIMIT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_command_ff <= req_command;
         s1_char_ff    <= req_name_char;
         s1_last_ff    <= req_name_last;
         s1_base_ff    <= req_entry_base;
         s1_ext_ff     <= req_entry_ext;
         s1_attr_ff    <= req_entry_attr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_COLLECT;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
         seen_ff  <= '0;
         for (int k = 0; k < NAME_BYTES; k++) begin
            name_ff[k] <= CHAR_SPACE;
         end
      end else if (advance) begin
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
         seen_ff  <= seen_in;
         for (int k = 0; k < NAME_BYTES; k++) begin
            name_ff[k] <= name_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;

endmodule
